// ===== hdl/gtg_pkg.sv =====
// shared types, constants and the arctangent table of the go-to-goal steering unit
`default_nettype none

package gtg_pkg;

    // vector width inside the rotator: 21 bit offsets scaled by 2^24 plus growth headroom
    localparam int unsigned VEC_W     = 48;
    localparam int unsigned ACC_W     = 32;
    localparam int unsigned ATAN_LEN  = 24;
    localparam int unsigned POS_W     = 20;
    localparam int unsigned DIFF_W    = 21;
    localparam int unsigned HEAD_W    = 16;
    localparam int unsigned DTOL_W    = 12;
    localparam int unsigned ATOL_W    = 14;
    localparam int unsigned PRESHIFT  = 24;
    localparam int unsigned IN_DATA_W = 56;
    localparam int unsigned OUT_DATA_W = 8;
    localparam int unsigned CMD_W     = 4;

    localparam logic [POS_W-1:0]  GOAL_RESET  = '0;
    localparam logic [DTOL_W-1:0] DTOL_RESET  = 12'd205;
    localparam logic [ATOL_W-1:0] ATOL_RESET  = 14'd1820;
    localparam logic [ACC_W-1:0]  HALF_TURN   = 32'h8000_0000;
    localparam logic [ACC_W-1:0]  ROUND_HALF  = 32'h0000_8000;
    localparam logic [HEAD_W-1:0] ERR_HALF    = 16'h8000;

    // register indexes of the configuration channel
    typedef enum logic [1:0] {
        CFG_GOAL_X    = 2'd0,
        CFG_GOAL_Y    = 2'd1,
        CFG_DIST_TOL  = 2'd2,
        CFG_ANGLE_TOL = 2'd3
    } gtg_cfg_idx_t;

    // atan(2^-i) with 2^32 as one full turn
    localparam logic [ACC_W-1:0] ATAN_TURNS [ATAN_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // payload carried down the rotator stages
    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic [ACC_W-1:0]        acc;
        logic [HEAD_W-1:0]       head;
        logic                    reached;
        logic                    zero;
    } gtg_vec_t;

    // steering command, lowest bit first: left, right, forward, halt
    typedef struct packed {
        logic halt;
        logic go_forward;
        logic turn_right;
        logic turn_left;
    } gtg_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/gtg_front.sv =====
// offset to goal, squared distance test and rotator set-up (three stages)
`default_nettype none

module gtg_front (
    input  wire logic                            clk,
    input  wire logic [2:0]                      en,
    input  wire logic [gtg_pkg::POS_W-1:0]       pos_x,
    input  wire logic [gtg_pkg::POS_W-1:0]       pos_y,
    input  wire logic [gtg_pkg::HEAD_W-1:0]      heading,
    input  wire logic [gtg_pkg::POS_W-1:0]       goal_x,
    input  wire logic [gtg_pkg::POS_W-1:0]       goal_y,
    input  wire logic [gtg_pkg::DTOL_W-1:0]      arrival_radius,
    output gtg_pkg::gtg_vec_t                    vec
);

    localparam int unsigned SQ_W = 2 * gtg_pkg::DIFF_W;

    // stage a: offsets
    logic signed [gtg_pkg::DIFF_W-1:0] dx_reg, dx_next;
    logic signed [gtg_pkg::DIFF_W-1:0] dy_reg, dy_next;
    logic [gtg_pkg::HEAD_W-1:0]        head_a_reg;

    // stage b: squares and folded vector
    logic [SQ_W-2:0]                   sqx_reg, sqx_next;
    logic [SQ_W-2:0]                   sqy_reg, sqy_next;
    logic [2*gtg_pkg::DTOL_W-1:0]      t2_reg, t2_next;
    logic signed [gtg_pkg::DIFF_W-1:0] fx_reg, fx_next;
    logic signed [gtg_pkg::DIFF_W-1:0] fy_reg, fy_next;
    logic                              neg_reg;
    logic                              zero_reg, zero_next;
    logic [gtg_pkg::HEAD_W-1:0]        head_b_reg;

    // stage c
    gtg_pkg::gtg_vec_t                 vec_reg, vec_next;

    logic signed [SQ_W-1:0]            prod_x;
    logic signed [SQ_W-1:0]            prod_y;
    logic [SQ_W-1:0]                   d2;

    always_comb
    begin
        dx_next = $signed({goal_x[gtg_pkg::POS_W-1], goal_x})
                - $signed({pos_x[gtg_pkg::POS_W-1], pos_x});
        dy_next = $signed({goal_y[gtg_pkg::POS_W-1], goal_y})
                - $signed({pos_y[gtg_pkg::POS_W-1], pos_y});
    end

    always_comb
    begin
        prod_x    = dx_reg * dx_reg;
        prod_y    = dy_reg * dy_reg;
        sqx_next  = prod_x[SQ_W-2:0];
        sqy_next  = prod_y[SQ_W-2:0];
        t2_next   = arrival_radius * arrival_radius;
        zero_next = (dx_reg == '0) && (dy_reg == '0);
        // fold the left half plane onto the right one, offset added later
        fx_next   = dx_reg[gtg_pkg::DIFF_W-1] ? -dx_reg : dx_reg;
        fy_next   = dx_reg[gtg_pkg::DIFF_W-1] ? -dy_reg : dy_reg;
    end

    always_comb
    begin
        d2               = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        vec_next.x       = {{(gtg_pkg::VEC_W - gtg_pkg::DIFF_W - gtg_pkg::PRESHIFT)
                             {fx_reg[gtg_pkg::DIFF_W-1]}}, fx_reg, {gtg_pkg::PRESHIFT{1'b0}}};
        vec_next.y       = {{(gtg_pkg::VEC_W - gtg_pkg::DIFF_W - gtg_pkg::PRESHIFT)
                             {fy_reg[gtg_pkg::DIFF_W-1]}}, fy_reg, {gtg_pkg::PRESHIFT{1'b0}}};
        vec_next.acc     = neg_reg ? gtg_pkg::HALF_TURN : '0;
        vec_next.head    = head_b_reg;
        vec_next.reached = d2 < SQ_W'(t2_reg);
        vec_next.zero    = zero_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            head_a_reg <= heading;
        end
        if (en[1])
        begin
            sqx_reg    <= sqx_next;
            sqy_reg    <= sqy_next;
            t2_reg     <= t2_next;
            fx_reg     <= fx_next;
            fy_reg     <= fy_next;
            neg_reg    <= dx_reg[gtg_pkg::DIFF_W-1];
            zero_reg   <= zero_next;
            head_b_reg <= head_a_reg;
        end
        if (en[2])
        begin
            vec_reg    <= vec_next;
        end
    end

    assign vec = vec_reg;

endmodule

`default_nettype wire

// ===== hdl/gtg_cordic.sv =====
// pipelined vectoring rotator, one micro-rotation per register stage
`default_nettype none

module gtg_cordic #(
    parameter int unsigned NUM_STAGES = 16
) (
    input  wire logic                  clk,
    input  wire logic [NUM_STAGES-1:0] en,
    input  wire gtg_pkg::gtg_vec_t     vec_in,
    output gtg_pkg::gtg_vec_t          vec_out
);

    gtg_pkg::gtg_vec_t stage_reg  [NUM_STAGES];
    gtg_pkg::gtg_vec_t stage_next [NUM_STAGES];

    for (genvar i = 0; i < NUM_STAGES; i++)
    begin : g_stage
        gtg_pkg::gtg_vec_t src;

        if (i == 0)
        begin : g_first
            assign src = vec_in;
        end
        else
        begin : g_rest
            assign src = stage_reg[i-1];
        end

        always_comb
        begin
            logic signed [gtg_pkg::VEC_W-1:0] xs;
            logic signed [gtg_pkg::VEC_W-1:0] ys;
            xs = src.x >>> i;
            ys = src.y >>> i;
            stage_next[i] = src;
            // rotate towards the x axis, sign of y picks the direction
            if (!src.y[gtg_pkg::VEC_W-1])
            begin
                stage_next[i].x   = src.x + ys;
                stage_next[i].y   = src.y - xs;
                stage_next[i].acc = src.acc + gtg_pkg::ATAN_TURNS[i];
            end
            else
            begin
                stage_next[i].x   = src.x - ys;
                stage_next[i].y   = src.y + xs;
                stage_next[i].acc = src.acc - gtg_pkg::ATAN_TURNS[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[i])
            begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

    assign vec_out = stage_reg[NUM_STAGES-1];

endmodule

`default_nettype wire

// ===== hdl/gtg_decide.sv =====
// heading error, dead band test and command register
`default_nettype none

module gtg_decide (
    input  wire logic                       clk,
    input  wire logic                       en,
    input  wire gtg_pkg::gtg_vec_t          vec_in,
    input  wire logic [gtg_pkg::ATOL_W-1:0] dead_band,
    output gtg_pkg::gtg_cmd_t               cmd
);

    gtg_pkg::gtg_cmd_t          cmd_reg, cmd_next;
    logic [gtg_pkg::ACC_W-1:0]  rounded;
    logic [gtg_pkg::HEAD_W-1:0] bearing;
    logic [gtg_pkg::HEAD_W-1:0] err;
    logic                       err_pos;
    logic [gtg_pkg::HEAD_W:0]   mag;

    always_comb
    begin
        rounded = vec_in.acc + gtg_pkg::ROUND_HALF;
        bearing = vec_in.zero ? vec_in.head
                              : rounded[gtg_pkg::ACC_W-1 -: gtg_pkg::HEAD_W];
        err     = bearing - vec_in.head;
        // a half-turn error counts as positive
        err_pos = !err[gtg_pkg::HEAD_W-1] || (err == gtg_pkg::ERR_HALF);
        mag     = err_pos ? {1'b0, err} : ({1'b0, ~err} + 1'b1);

        cmd_next.halt = 1'b0;
        if (vec_in.reached)
        begin
            cmd_next.turn_left  = 1'b1;
            cmd_next.turn_right = 1'b1;
            cmd_next.go_forward = 1'b1;
        end
        else if (mag > (gtg_pkg::HEAD_W+1)'(dead_band))
        begin
            cmd_next.turn_left  = err_pos;
            cmd_next.turn_right = !err_pos;
            cmd_next.go_forward = 1'b0;
        end
        else
        begin
            cmd_next.turn_left  = 1'b0;
            cmd_next.turn_right = 1'b0;
            cmd_next.go_forward = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd = cmd_reg;

endmodule

`default_nettype wire

// ===== hdl/go_to_goal_steering_decision_unit.sv =====
// go-to-goal steering unit: pose in, one steering command out per pose
//
// s_axis carries one pose per transaction; m_axis returns one command per pose,
// in order. the goal and both tolerances sit in registers written through the
// cfg channel (cfg_ready is always high); write them only while no pose is in
// flight.
// the path runs through three set-up stages (offset, squares, distance
// compare), one stage per rotator micro-rotation and one decision stage.
// throughput: one pose per cycle while m_axis is not stalled, set by the
// fully pipelined rotator.
// every stage carries a valid bit and only holds when the stage after it is
// full and held, so while m_axis is stalled new poses are still taken until
// every bubble is filled; nothing is dropped or repeated.
// reset clears all valid bits and loads the goal at the origin, arrival radius
// 205 and heading dead band 1820.
`default_nettype none

module go_to_goal_steering_decision_unit #(
    parameter int unsigned CORDIC_STAGES = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output wire logic                            s_axis_tready,
    // pos_x [19:0], pos_y [39:20], heading [55:40]
    input  wire logic [gtg_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output wire logic                            m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // turn_left [0], turn_right [1], go_forward [2], halt [3], zero fill [7:4]
    output wire logic [gtg_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input  wire logic                            cfg_valid,
    output wire logic                            cfg_ready,
    input  wire logic [1:0]                      cfg_index,
    input  wire logic [gtg_pkg::POS_W-1:0]       cfg_data
);

    localparam int unsigned NUM_ROT =
        (CORDIC_STAGES < gtg_pkg::ATAN_LEN) ? CORDIC_STAGES : gtg_pkg::ATAN_LEN;
    localparam int unsigned FRONT_STAGES = 3;
    localparam int unsigned DEPTH = FRONT_STAGES + NUM_ROT + 1;

    logic [gtg_pkg::POS_W-1:0]  goal_x_reg;
    logic [gtg_pkg::POS_W-1:0]  goal_y_reg;
    logic [gtg_pkg::DTOL_W-1:0] dtol_reg;
    logic [gtg_pkg::ATOL_W-1:0] atol_reg;

    logic [DEPTH-1:0]           valid_reg, valid_next;
    logic [DEPTH:0]             adv;

    gtg_pkg::gtg_vec_t          front_vec;
    gtg_pkg::gtg_vec_t          rot_vec;
    gtg_pkg::gtg_cmd_t          cmd;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_x_reg <= gtg_pkg::GOAL_RESET;
            goal_y_reg <= gtg_pkg::GOAL_RESET;
            dtol_reg   <= gtg_pkg::DTOL_RESET;
            atol_reg   <= gtg_pkg::ATOL_RESET;
        end
        else if (cfg_valid)
        begin
            case (gtg_pkg::gtg_cfg_idx_t'(cfg_index))
                gtg_pkg::CFG_GOAL_X:    goal_x_reg <= cfg_data;
                gtg_pkg::CFG_GOAL_Y:    goal_y_reg <= cfg_data;
                gtg_pkg::CFG_DIST_TOL:  dtol_reg   <= cfg_data[gtg_pkg::DTOL_W-1:0];
                gtg_pkg::CFG_ANGLE_TOL: atol_reg   <= cfg_data[gtg_pkg::ATOL_W-1:0];
                default:                ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // a stage loads when it is empty or its successor moves on
    always_comb
    begin
        adv[DEPTH] = m_axis_tready;
        for (int k = DEPTH - 1; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
        valid_next = valid_reg;
        if (adv[0])
        begin
            valid_next[0] = s_axis_tvalid;
        end
        for (int k = 1; k < DEPTH; k++)
        begin
            if (adv[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    gtg_front u_front (
        .clk            (clk),
        .en             (adv[FRONT_STAGES-1:0]),
        .pos_x          (s_axis_tdata[19:0]),
        .pos_y          (s_axis_tdata[39:20]),
        .heading        (s_axis_tdata[55:40]),
        .goal_x         (goal_x_reg),
        .goal_y         (goal_y_reg),
        .arrival_radius (dtol_reg),
        .vec            (front_vec)
    );

    gtg_cordic #(
        .NUM_STAGES (NUM_ROT)
    ) u_cordic (
        .clk     (clk),
        .en      (adv[FRONT_STAGES +: NUM_ROT]),
        .vec_in  (front_vec),
        .vec_out (rot_vec)
    );

    gtg_decide u_decide (
        .clk       (clk),
        .en        (adv[DEPTH-1]),
        .vec_in    (rot_vec),
        .dead_band (atol_reg),
        .cmd       (cmd)
    );

    assign s_axis_tready = adv[0];
    assign m_axis_tvalid = valid_reg[DEPTH-1];
    assign m_axis_tdata  = {{(gtg_pkg::OUT_DATA_W - gtg_pkg::CMD_W){1'b0}}, cmd};

endmodule

`default_nettype wire

// ===== hdl/gtg_checker.sv =====
// port-level checks of the steering unit and their binding
`default_nettype none

module gtg_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [gtg_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    // a command is either a single action or goal reached (all three set)
    a_cmd_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($countones(m_axis_tdata[2:0]) == 1)
                       || (m_axis_tdata[2:0] == 3'b111))
        else $error("malformed steering command");

    // halt and the fill bits never set
    a_halt_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[gtg_pkg::OUT_DATA_W-1:3] == '0))
        else $error("halt or fill bits set");

    // held result stays put while the receiver stalls
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed during stall");

    // nothing comes out straight after reset is released
    a_reset_idle: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind go_to_goal_steering_decision_unit gtg_checker u_gtg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== dv/go_to_goal_steering_decision_unit_tb.sv =====
// go-to-goal steering unit testbench: fixed and random poses checked by a bit-exact steering predictor
module go_to_goal_steering_decision_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STAGES           = 16;
    localparam int LATENCY          = STAGES + 4;
    localparam int HALF_PERIOD      = 2;
    localparam int STALL_LIMIT      = 4000;
    localparam int PHASES           = 6;
    localparam int RANDOM_PER_PHASE = 305;

    // atan(2^-i), 2^32 per turn
    localparam logic [31:0] ARCTAN_STEP [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // same layout as s_axis_tdata, pos_x in the lowest bits
    typedef struct packed {
        logic [15:0] heading;
        logic [19:0] pos_y;
        logic [19:0] pos_x;
    } pose_t;

    typedef struct {
        pose_t pose;
        bit    drain;
    } pose_req_t;

    logic                           clk           = 1'b0;
    logic                           rst_n         = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [gtg_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [gtg_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                           cfg_valid     = 1'b0;
    logic                           cfg_ready;
    logic [1:0]                     cfg_index     = '0;
    logic [gtg_pkg::POS_W-1:0]      cfg_data      = '0;

    // register copies used for prediction
    logic [19:0] aim_x         = gtg_pkg::GOAL_RESET;
    logic [19:0] aim_y         = gtg_pkg::GOAL_RESET;
    logic [11:0] arrive_radius = gtg_pkg::DTOL_RESET;
    logic [13:0] dead_band     = gtg_pkg::ATOL_RESET;

    pose_req_t          pose_q[$];
    gtg_pkg::gtg_cmd_t  cmd_q[$];

    int fault_count = 0;
    int idle_cycles = 0;
    int send_gap    = 0;
    int stall_left  = 0;
    int idle_pct    = 0;
    int stall_pct   = 0;
    bit calm        = 1'b0;

    go_to_goal_steering_decision_unit #(
        .CORDIC_STAGES(STAGES)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic logic signed [20:0] offset(logic [19:0] target, logic [19:0] pos);
        return {target[19], target} - {pos[19], pos};
    endfunction

    // vectoring rotation, floor shifts, 32 bit wrapping angle
    function automatic logic [15:0] goal_bearing(logic signed [20:0] dx, logic signed [20:0] dy);
        logic signed [47:0] x;
        logic signed [47:0] y;
        logic signed [47:0] xs;
        logic signed [47:0] ys;
        logic [31:0]        acc;
        logic [31:0]        rounded;
        x   = {{3{dx[20]}}, dx, 24'd0};
        y   = {{3{dy[20]}}, dy, 24'd0};
        acc = '0;
        if (x < 0)
        begin
            x   = -x;
            y   = -y;
            acc = gtg_pkg::HALF_TURN;
        end
        for (int i = 0; i < STAGES && i < 24; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x   = x + ys;
                y   = y - xs;
                acc = acc + ARCTAN_STEP[i];
            end
            else
            begin
                x   = x - ys;
                y   = y + xs;
                acc = acc - ARCTAN_STEP[i];
            end
        end
        rounded = acc + gtg_pkg::ROUND_HALF;
        return rounded[31:16];
    endfunction

    function automatic logic [15:0] bearing_from(logic [19:0] px, logic [19:0] py);
        return goal_bearing(offset(aim_x, px), offset(aim_y, py));
    endfunction

    function automatic gtg_pkg::gtg_cmd_t steer(pose_t p);
        logic signed [20:0] dx;
        logic signed [20:0] dy;
        longint             d2;
        longint             t2;
        logic [15:0]        aim;
        logic [15:0]        e;
        int                 err;
        int                 mag;
        gtg_pkg::gtg_cmd_t  c;
        dx = offset(aim_x, p.pos_x);
        dy = offset(aim_y, p.pos_y);
        d2 = longint'(dx) * longint'(dx) + longint'(dy) * longint'(dy);
        t2 = longint'(arrive_radius) * longint'(arrive_radius);
        c  = '0;
        if (d2 < t2)
        begin
            c.turn_left  = 1'b1;
            c.turn_right = 1'b1;
            c.go_forward = 1'b1;
        end
        else
        begin
            aim = (dx == 0 && dy == 0) ? p.heading : goal_bearing(dx, dy);
            e   = aim - p.heading;
            // exactly half a turn counts as positive
            err = (e == gtg_pkg::ERR_HALF) ? 32768 : int'($signed(e));
            mag = (err < 0) ? -err : err;
            if (mag > int'(dead_band))
            begin
                if (err > 0)
                    c.turn_left = 1'b1;
                else
                    c.turn_right = 1'b1;
            end
            else
                c.go_forward = 1'b1;
        end
        return c;
    endfunction

    function automatic pose_t make_pose(logic [19:0] x, logic [19:0] y, logic [15:0] h);
        pose_t p;
        p.pos_x   = x;
        p.pos_y   = y;
        p.heading = h;
        return p;
    endfunction

    function automatic pose_t random_pose();
        return make_pose(20'($urandom), 20'($urandom), 16'($urandom));
    endfunction

    // near the arrival radius, near the dead band edges or the half turn, or anywhere
    function automatic pose_t mixed_pose();
        pose_t       p;
        int          span;
        logic [15:0] b;
        int          k;
        p    = random_pose();
        k    = $urandom_range(9);
        span = int'(arrive_radius) + 4;
        if (k < 3)
        begin
            p.pos_x = aim_x + 20'($urandom_range(2 * span) - span);
            p.pos_y = aim_y + 20'($urandom_range(2 * span) - span);
        end
        else if (k < 6)
        begin
            if ($urandom_range(1))
            begin
                p.pos_x = aim_x + 20'($urandom_range(8192) - 4096);
                p.pos_y = aim_y + 20'($urandom_range(8192) - 4096);
            end
            b = bearing_from(p.pos_x, p.pos_y);
            case ($urandom_range(4))
                0:       p.heading = b - 16'(dead_band);
                1:       p.heading = b + 16'(dead_band);
                2:       p.heading = b - 16'(dead_band) - 16'($urandom_range(1, 3));
                3:       p.heading = b + 16'(dead_band) + 16'($urandom_range(1, 3));
                default: p.heading = b + gtg_pkg::ERR_HALF + 16'd1 - 16'($urandom_range(2));
            endcase
        end
        return p;
    endfunction

    function automatic void queue_pose(pose_t p, bit drain = 1'b0);
        pose_req_t r;
        r.pose  = p;
        r.drain = drain;
        pose_q.push_back(r);
    endfunction

    task automatic check_field(string name, logic want, logic got);
        if (want !== got)
        begin
            $error("%s: expected %0b, actual %0b", name, want, got);
            fault_count++;
        end
    endtask

    task automatic write_reg(gtg_pkg::gtg_cfg_idx_t idx, logic [19:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            gtg_pkg::CFG_GOAL_X:    aim_x = value;
            gtg_pkg::CFG_GOAL_Y:    aim_y = value;
            gtg_pkg::CFG_DIST_TOL:  arrive_radius = value[11:0];
            gtg_pkg::CFG_ANGLE_TOL: dead_band = value[13:0];
            default:                ;
        endcase
    endtask

    // tolerance writes carry junk in the unused upper bits
    task automatic configure(logic [19:0] gx, logic [19:0] gy, logic [11:0] dtol,
                             logic [13:0] atol);
        logic [19:0] junk;
        junk = 20'($urandom);
        write_reg(gtg_pkg::CFG_GOAL_X, gx);
        write_reg(gtg_pkg::CFG_GOAL_Y, gy);
        write_reg(gtg_pkg::CFG_DIST_TOL, {junk[19:12], dtol});
        write_reg(gtg_pkg::CFG_ANGLE_TOL, {junk[19:14], atol});
    endtask

    // sampled away from the rising edge so the driver's updates have settled
    task automatic wait_drained();
        @(negedge clk);
        while (pose_q.size() != 0 || s_axis_tvalid || cmd_q.size() != 0)
            @(negedge clk);
    endtask

    // pose driver
    always @(posedge clk or negedge rst_n)
    begin
        pose_req_t req;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                cmd_q.push_back(steer(pose_t'(s_axis_tdata)));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap == 0 && !calm && $urandom_range(99) < idle_pct)
                    send_gap = $urandom_range(1, 15);
                if (send_gap != 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pose_q.size() != 0 && !(pose_q[0].drain && cmd_q.size() != 0))
                begin
                    req = pose_q.pop_front();
                    s_axis_tdata  <= req.pose;
                    s_axis_tvalid <= 1'b1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // command monitor
    always @(posedge clk or negedge rst_n)
    begin
        gtg_pkg::gtg_cmd_t got;
        gtg_pkg::gtg_cmd_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = gtg_pkg::gtg_cmd_t'(m_axis_tdata[gtg_pkg::CMD_W-1:0]);
                if (cmd_q.size() == 0)
                begin
                    $error("command transaction %b with no pose pending", got);
                    fault_count++;
                end
                else
                begin
                    want = cmd_q.pop_front();
                    check_field("turn_left", want.turn_left, got.turn_left);
                    check_field("turn_right", want.turn_right, got.turn_right);
                    check_field("go_forward", want.go_forward, got.go_forward);
                    check_field("halt", want.halt, got.halt);
                end
            end
            if (stall_left == 0 && !calm && $urandom_range(99) < stall_pct)
                stall_left = $urandom_range(1, 15);
            if (stall_left != 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("go_to_goal_steering_decision_unit: mismatch");
        $finish;
    end

    initial
    begin
        logic [15:0] b;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph != 0)
            begin
                wait_drained();
                repeat (2) @(posedge clk);
            end
            case (ph)
                0:
                begin
                    idle_pct  = 10;
                    stall_pct = 10;
                end
                1:
                begin
                    configure(20'h7FFFF, 20'h80000, 12'hFFF, 14'h3FFF);
                    idle_pct  = 0;
                    stall_pct = 25;
                end
                2:
                begin
                    configure(20'h80000, 20'h7FFFF, 12'd0, 14'd0);
                    idle_pct  = 25;
                    stall_pct = 0;
                end
                3:
                begin
                    configure(20'($urandom), 20'($urandom), 12'($urandom), 14'($urandom));
                    idle_pct  = 5;
                    stall_pct = 5;
                end
                4:
                begin
                    configure(20'($urandom_range(8000)) - 20'd4000,
                              20'($urandom_range(8000)) - 20'd4000,
                              12'($urandom_range(600)), 14'($urandom_range(4000)));
                    idle_pct  = 15;
                    stall_pct = 15;
                end
                default:
                begin
                    configure(20'($urandom), 20'($urandom), 12'($urandom), 14'($urandom));
                    idle_pct  = 0;
                    stall_pct = 0;
                end
            endcase
            calm = (ph == PHASES - 1);

            if (ph == 0)
            begin
                // arrival radius boundary around the origin
                queue_pose(make_pose(20'd0, 20'd0, 16'd0));
                queue_pose(make_pose(20'd204, 20'd0, 16'h8000));
                queue_pose(make_pose(20'd205, 20'd0, 16'd0));
                queue_pose(make_pose(20'd0, 20'hFFF33, 16'h7FFF));
                // position and heading extremes
                queue_pose(make_pose(20'h80000, 20'h80000, 16'h7FFF));
                queue_pose(make_pose(20'h7FFFF, 20'h7FFFF, 16'h8000));
                queue_pose(make_pose(20'h80000, 20'h7FFFF, 16'h0000));
                queue_pose(make_pose(20'h7FFFF, 20'h80000, 16'h4000));
                // goal on each axis direction
                queue_pose(make_pose(20'd100000, 20'd0, 16'd0));
                queue_pose(make_pose(20'd0, 20'd100000, 16'd0));
                queue_pose(make_pose(20'hE7960, 20'd0, 16'd0));
                queue_pose(make_pose(20'd0, 20'hE7960, 16'd0));
                // half-turn error and both edges of the dead band
                b = bearing_from(20'hE7960, 20'd30000);
                queue_pose(make_pose(20'hE7960, 20'd30000, b + gtg_pkg::ERR_HALF));
                queue_pose(make_pose(20'hE7960, 20'd30000, b - 16'(dead_band)));
                queue_pose(make_pose(20'hE7960, 20'd30000, b + 16'(dead_band)));
                queue_pose(make_pose(20'hE7960, 20'd30000, b - 16'(dead_band) - 16'd1));
                queue_pose(make_pose(20'hE7960, 20'd30000, b + 16'(dead_band) + 16'd1));
                queue_pose(random_pose(), 1'b1);
            end
            if (ph == 2)
            begin
                // zero radius: pose on the goal has no bearing, so it goes forward
                queue_pose(make_pose(aim_x, aim_y, 16'h1234));
                queue_pose(make_pose(aim_x, aim_y, 16'($urandom)), 1'b1);
                b = bearing_from(20'd0, 20'd0);
                queue_pose(make_pose(20'd0, 20'd0, b));
                queue_pose(make_pose(20'd0, 20'd0, b - 16'd1));
            end
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                queue_pose(mixed_pose(), !calm && $urandom_range(149) == 0);
        end
        wait_drained();
        repeat (2 * LATENCY) @(posedge clk);
        if (fault_count == 0)
            $display("go_to_goal_steering_decision_unit: match");
        else
            $display("go_to_goal_steering_decision_unit: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/gtg_pkg.sv
hdl/gtg_front.sv
hdl/gtg_cordic.sv
hdl/gtg_decide.sv
hdl/go_to_goal_steering_decision_unit.sv
hdl/gtg_checker.sv
dv/go_to_goal_steering_decision_unit_tb.sv
